@@ rtl/core/ftb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftb_pkg
// shared types and codes of the frame retransmit timer bank
// ----------------------------------------------------------------------------
package ftb_pkg;

	localparam int SEQ_W     = 3;
	localparam int KIND_W    = 2;
	localparam int TICKS_W   = 16;
	localparam int TDATA_W   = 8;

	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

	localparam logic [TICKS_W-1:0] TIMEOUT_RST = 16'd100;

	// controller to datapath
	typedef struct packed {
		logic take;      // input item accepted
		logic idx_clr;
		logic idx_inc;
		logic rd_en;     // read tick count at idx
		logic upd;       // count down or expire entry at idx
		logic mask_clr;
		logic emit;      // load output register from idx
	} ftb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic armed_cur;
		logic mask_cur;
		logic mask_empty;
		logic idx_last;
		logic out_free;
	} ftb_status_t;

endpackage

@@ rtl/core/frame_retransmit_timer_bank_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_retransmit_timer_bank_unit
// one retransmission timer per frame sequence number, expiries on tick items
// ----------------------------------------------------------------------------
// channel   direction  signals                          contents
// s_        in         s_tvalid s_tready s_tdata s_tuser  tdata: frame_seq, tuser: kind
// m_        out        m_tvalid m_tready m_tdata m_tlast  tdata: expired_seq, tlast: last_expiry
// cfg_      in         cfg_we cfg_wdata                 timeout_ticks
//
// start and stop items are handled in the cycle that accepts them.
// a tick walks the bank one entry a cycle, an armed entry through a read
// state and then an update state, as the tick count ram read is registered;
// it then drains the expiry mask one entry a cycle while the output is free
// and goes idle once the mask is empty.
// s_tready is low while a tick is worked on; a stalled m_tready holds the drain.
// reset clears armed bits, the expiry mask and output valid, and sets timeout_ticks to 100.
// ----------------------------------------------------------------------------
module frame_retransmit_timer_bank_unit
	import ftb_pkg::*;
#(
	parameter int NUM_SEQ = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [2:0] frame_seq
	input  logic [KIND_W-1:0]  s_tuser,   // [1:0] kind
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [2:0] expired_seq
	output logic               m_tlast,
	input  logic               cfg_we,
	input  logic [TICKS_W-1:0] cfg_wdata
);

	ftb_cmd_t         cmd;
	ftb_status_t      sts;
	logic [SEQ_W-1:0] out_seq;

	ftb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ftb_dp #(
		.NUM_SEQ (NUM_SEQ)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_kind   (s_tuser),
		.in_seq    (s_tdata[SEQ_W-1:0]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_seq   (out_seq),
		.out_last  (m_tlast)
	);

	assign m_tdata = TDATA_W'(out_seq);

endmodule

@@ rtl/core/ftb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ftb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/ftb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftb_ctrl
// sequencer: takes items, walks the bank on a tick, then drains expiries
// ----------------------------------------------------------------------------
module ftb_ctrl
	import ftb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] in_kind,
	output logic              in_ready,
	input  ftb_status_t       sts,
	output ftb_cmd_t          cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_kind == KIND_TICK) begin
						cmd.idx_clr  = 1'b1;
						cmd.mask_clr = 1'b1;
						state_nxt    = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (sts.armed_cur) begin
					cmd.rd_en = 1'b1;
					state_nxt = ST_UPD;
				end else if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = ST_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = ST_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = ST_SCAN;
				end
			end
			ST_EMIT: begin
				if (sts.mask_empty) begin
					state_nxt = ST_IDLE;
				end else if (sts.mask_cur) begin
					if (sts.out_free) begin
						cmd.emit    = 1'b1;
						cmd.idx_inc = !sts.idx_last;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// a walk never leaves the bank before its last entry
	a_scan_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EMIT && state_nxt == ST_EMIT) |-> sts.idx_last)
		else $error("walk ended before last entry");

endmodule

@@ rtl/core/ftb_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftb_dp
// timer datapath: armed bits, tick count ram, expiry mask, output register
// ----------------------------------------------------------------------------
module ftb_dp
	import ftb_pkg::*;
#(
	parameter int NUM_SEQ = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ftb_cmd_t           cmd,
	output ftb_status_t        sts,
	input  logic [KIND_W-1:0]  in_kind,
	input  logic [SEQ_W-1:0]   in_seq,
	input  logic               cfg_we,
	input  logic [TICKS_W-1:0] cfg_wdata,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SEQ_W-1:0]   out_seq,
	output logic               out_last
);

	localparam int IW = $clog2(NUM_SEQ);
	localparam logic [IW-1:0] IDX_LAST = IW'(NUM_SEQ - 1);

	logic [TICKS_W-1:0] timeout_q;
	logic [NUM_SEQ-1:0] armed_q;
	logic [NUM_SEQ-1:0] mask_q;
	logic [IW-1:0]      idx_q;
	logic               out_valid_q;
	logic [SEQ_W-1:0]   out_seq_q;
	logic               out_last_q;

	logic [IW+SEQ_W-1:0] seq_ext;
	logic [IW+SEQ_W-1:0] idx_ext;
	logic [IW-1:0]       seq_idx;
	logic                seq_ok;
	logic                do_start;
	logic                do_stop;
	logic [TICKS_W-1:0]  timeout_eff;
	logic [TICKS_W-1:0]  rdata;
	logic                expire;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [TICKS_W-1:0]  ram_wdata;
	logic [NUM_SEQ-1:0]  idx_hot;
	logic                out_free;

	assign seq_ext     = (IW + SEQ_W)'(in_seq);
	assign idx_ext     = (IW + SEQ_W)'(idx_q);
	assign seq_idx     = seq_ext[IW-1:0];
	assign seq_ok      = 32'(in_seq) < 32'(NUM_SEQ);
	assign do_start    = cmd.take && (in_kind == KIND_START) && seq_ok;
	assign do_stop     = cmd.take && (in_kind == KIND_STOP) && seq_ok;
	assign timeout_eff = (timeout_q == '0) ? TICKS_W'(1) : timeout_q;
	assign expire      = rdata <= TICKS_W'(1);
	assign idx_hot     = NUM_SEQ'(1) << idx_q;
	assign out_free    = !out_valid_q || out_ready;

	// start items and the tick walk never share a cycle
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = rdata - TICKS_W'(1);
		if (do_start) begin
			ram_we    = 1'b1;
			ram_waddr = seq_idx;
			ram_wdata = timeout_eff;
		end else if (cmd.upd && !expire) begin
			ram_we = 1'b1;
		end
	end

	ftb_ram #(
		.WIDTH (TICKS_W),
		.DEPTH (NUM_SEQ)
	) u_ticks_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RST;
			armed_q     <= '0;
			mask_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (do_start) begin
				armed_q[seq_idx] <= 1'b1;
			end else if (do_stop) begin
				armed_q[seq_idx] <= 1'b0;
			end else if (cmd.upd && expire) begin
				armed_q[idx_q] <= 1'b0;
			end
			if (cmd.mask_clr) begin
				mask_q <= '0;
			end else if (cmd.upd && expire) begin
				mask_q[idx_q] <= 1'b1;
			end else if (cmd.emit) begin
				mask_q[idx_q] <= 1'b0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_seq_q  <= idx_ext[SEQ_W-1:0];
			// last when no other expiry is left in the mask
			out_last_q <= (mask_q & ~idx_hot) == '0;
		end
	end

	assign sts.armed_cur  = armed_q[idx_q];
	assign sts.mask_cur   = mask_q[idx_q];
	assign sts.mask_empty = mask_q == '0;
	assign sts.idx_last   = idx_q == IDX_LAST;
	assign sts.out_free   = out_free;

	assign out_valid = out_valid_q;
	assign out_seq   = out_seq_q;
	assign out_last  = out_last_q;

	a_upd_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> $past(cmd.rd_en))
		else $error("tick count used without a read");

	a_upd_armed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> armed_q[idx_q])
		else $error("count down of a disarmed timer");

	a_emit_marked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (mask_q[idx_q] && out_free))
		else $error("expiry reported for unmarked entry or full output");

	a_expire_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd && expire) |=> !armed_q[$past(idx_q)])
		else $error("expired timer still armed");

endmodule
